### design/tdfp_pkg.sv
package tdfp_pkg;

   // mode codes
   localparam logic [2:0] MODE_IDLE      = 3'd0;
   localparam logic [2:0] MODE_COUNTDOWN = 3'd1;
   localparam logic [2:0] MODE_PLAYING   = 3'd2;
   localparam logic [2:0] MODE_LEVELUP   = 3'd3;
   localparam logic [2:0] MODE_GAMEOVER  = 3'd4;

   // strip selector codes
   localparam logic [1:0] STRIP_NONE = 2'd0;
   localparam logic [1:0] STRIP_X    = 2'd1;
   localparam logic [1:0] STRIP_Y    = 2'd2;
   localparam logic [1:0] STRIP_Z    = 2'd3;

   // field selector codes
   localparam logic [3:0] FIELD_NONE = 4'd0;
   localparam logic [3:0] FIELD_Q    = 4'd1;
   localparam logic [3:0] FIELD_R    = 4'd2;
   localparam logic [3:0] FIELD_S    = 4'd3;
   localparam logic [3:0] FIELD_UA   = 4'd4;
   localparam logic [3:0] FIELD_LA   = 4'd5;
   localparam logic [3:0] FIELD_UB   = 4'd6;
   localparam logic [3:0] FIELD_LB   = 4'd7;
   localparam logic [3:0] FIELD_UE   = 4'd8;
   localparam logic [3:0] FIELD_LE   = 4'd9;

   // ASCII characters of interest
   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_I  = 8'h49;
   localparam logic [7:0] CH_C  = 8'h43;
   localparam logic [7:0] CH_P  = 8'h50;
   localparam logic [7:0] CH_L  = 8'h4C;
   localparam logic [7:0] CH_G  = 8'h47;
   localparam logic [7:0] CH_X  = 8'h58;
   localparam logic [7:0] CH_Y  = 8'h59;
   localparam logic [7:0] CH_Z  = 8'h5A;
   localparam logic [7:0] CH_Q  = 8'h51;
   localparam logic [7:0] CH_R  = 8'h52;
   localparam logic [7:0] CH_S  = 8'h53;
   localparam logic [7:0] CH_UA = 8'h41;
   localparam logic [7:0] CH_LA = 8'h61;
   localparam logic [7:0] CH_UB = 8'h42;
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] CH_UE = 8'h45;
   localparam logic [7:0] CH_LE = 8'h65;

   // classification of one received character
   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic       is_field;
      logic [3:0] field;
      logic       is_mode;
      logic [2:0] mode;
      logic       is_strip;
      logic [1:0] strip;
   } char_class_type;

endpackage

### design/tdfp_char_decode.sv
module tdfp_char_decode
   import tdfp_pkg::*;
(
   input  logic [7:0]     ch,
   output char_class_type cls
);

   // sort the character into digit, field letter, mode letter or strip letter
   always_comb begin
      cls          = '0;
      cls.is_digit = ch inside {[CH_0:CH_9]};
      cls.digit    = 4'(ch - CH_0);
      case (ch)
         CH_Q:  begin cls.is_field = 1'b1; cls.field = FIELD_Q;  end
         CH_R:  begin cls.is_field = 1'b1; cls.field = FIELD_R;  end
         CH_S:  begin cls.is_field = 1'b1; cls.field = FIELD_S;  end
         CH_UA: begin cls.is_field = 1'b1; cls.field = FIELD_UA; end
         CH_LA: begin cls.is_field = 1'b1; cls.field = FIELD_LA; end
         CH_UB: begin cls.is_field = 1'b1; cls.field = FIELD_UB; end
         CH_LB: begin cls.is_field = 1'b1; cls.field = FIELD_LB; end
         CH_UE: begin cls.is_field = 1'b1; cls.field = FIELD_UE; end
         CH_LE: begin cls.is_field = 1'b1; cls.field = FIELD_LE; end
         CH_I:  begin cls.is_mode = 1'b1; cls.mode = MODE_IDLE;      end
         CH_C:  begin cls.is_mode = 1'b1; cls.mode = MODE_COUNTDOWN; end
         CH_P:  begin cls.is_mode = 1'b1; cls.mode = MODE_PLAYING;   end
         CH_L:  begin cls.is_mode = 1'b1; cls.mode = MODE_LEVELUP;   end
         CH_G:  begin cls.is_mode = 1'b1; cls.mode = MODE_GAMEOVER;  end
         CH_X:  begin cls.is_strip = 1'b1; cls.strip = STRIP_X; end
         CH_Y:  begin cls.is_strip = 1'b1; cls.strip = STRIP_Y; end
         CH_Z:  begin cls.is_strip = 1'b1; cls.strip = STRIP_Z; end
         default: begin
         end
      endcase
   end

endmodule

### design/tdfp_accum.sv
module tdfp_accum #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic [VALUE_WIDTH-1:0] acc,
   input  logic                   wrap,
   input  logic [3:0]             digit,
   output logic [VALUE_WIDTH-1:0] acc_next,
   output logic                   wrap_next
);

   logic [VALUE_WIDTH+3:0] acc_ext;
   logic [VALUE_WIDTH+3:0] sum;

   // acc*10 + digit as shift-adds; any bit above the value width is a wrap
   always_comb begin
      acc_ext   = {4'b0, acc};
      sum       = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_WIDTH{1'b0}}, digit};
      acc_next  = sum[VALUE_WIDTH-1:0];
      wrap_next = wrap | (|sum[VALUE_WIDTH+3:VALUE_WIDTH]);
   end

endmodule

### design/tagged_decimal_field_parser.sv
// channel  | dir | tdata                     | tuser
// ---------+-----+---------------------------+------------------
// req_     | in  | rx_byte                   | -
// rsp_     | out | write fields, mode, sels  | write_valid
//
// One beat in, one beat out, one byte per cycle sustained unless the result
// stalls; input register, then decode and multiply-add into result register.
// Synchronous active-high reset clears mode, selectors, accumulator and
// wrap flag. A stalled result holds in place while the input register still
// takes one more beat; the parser state advances only as results move.
module tagged_decimal_field_parser
   import tdfp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] write_strip, [5:2] write_slot, [37:6] write_value,
   // [38] write_overflowed, [41:39] mode_now, [43:42] strip_select_now,
   // [47:44] field_select_now
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser    // [0] write_valid
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   logic [2:0]             mode_ff, mode_in;
   logic [1:0]             strip_ff, strip_in;
   logic [3:0]             field_ff, field_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   wrap_ff, wrap_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   logic                   advance;
   logic                   stage_go;
   char_class_type         cls;
   logic [VALUE_WIDTH-1:0] acc_sum;
   logic                   wrap_sum;
   logic [VALUE_WIDTH+31:0] acc_wide;
   logic                   wr_valid;
   logic [1:0]             wr_strip;
   logic [3:0]             wr_slot;
   logic [31:0]            wr_value;
   logic                   wr_ovf;

   // handshake
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign stage_go   = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   tdfp_char_decode u_decode (
      .ch  (in_byte_ff),
      .cls (cls)
   );

   tdfp_accum #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_accum (
      .acc       (acc_ff),
      .wrap      (wrap_ff),
      .digit     (cls.digit),
      .acc_next  (acc_sum),
      .wrap_next (wrap_sum)
   );

   assign acc_wide = {32'b0, acc_ff};

   // next state and write fields for the byte in the input register
   always_comb begin
      mode_in  = mode_ff;
      strip_in = strip_ff;
      field_in = field_ff;
      acc_in   = acc_ff;
      wrap_in  = wrap_ff;
      wr_valid = 1'b0;
      wr_strip = 2'd0;
      wr_slot  = 4'd0;
      wr_value = 32'd0;
      wr_ovf   = 1'b0;
      if (stage_go) begin
         if (cls.is_digit) begin
            acc_in  = acc_sum;
            wrap_in = wrap_sum;
         end else begin
            // close the number into the selected slot
            if (strip_ff != STRIP_NONE && field_ff != FIELD_NONE) begin
               wr_valid = 1'b1;
               wr_strip = strip_ff - 2'd1;
               wr_slot  = field_ff - 4'd1;
               wr_value = acc_wide[31:0];
               wr_ovf   = wrap_ff;
            end
            acc_in  = '0;
            wrap_in = 1'b0;
            if (cls.is_field) begin
               field_in = cls.field;
            end else if (cls.is_mode) begin
               mode_in = cls.mode;
            end else if (cls.is_strip) begin
               strip_in = cls.strip;
            end else begin
               // unknown character
               mode_in  = MODE_LEVELUP;
               strip_in = STRIP_NONE;
               field_in = FIELD_NONE;
            end
         end
      end
   end

   // valid flags
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      rsp_data_in = {field_in, strip_in, mode_in, wr_ovf, wr_value, wr_slot, wr_strip};
      rsp_user_in = wr_valid;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         strip_ff     <= STRIP_NONE;
         field_ff     <= FIELD_NONE;
         acc_ff       <= '0;
         wrap_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         strip_ff     <= strip_in;
         field_ff     <= field_in;
         acc_ff       <= acc_in;
         wrap_ff      <= wrap_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (stage_go) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

`ifndef SYNTHESIS
   // a beat without a write carries zero write fields
   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[38:0] == 39'd0))
      else $error("write fields nonzero without write_valid");

   // a write targets a real strip and slot
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[1:0] != 2'd3 && rsp_tdata[5:2] <= 4'd8))
      else $error("write destination out of range");

   // a non-digit byte clears the number
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_go && !cls.is_digit) |=> (acc_ff == '0 && !wrap_ff))
      else $error("accumulator not cleared after delimiter");

   // parser state only moves when a byte is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !stage_go |=> ($stable(acc_ff) && $stable(mode_ff) && $stable(field_ff)))
      else $error("parser state changed without a byte");
`endif

endmodule
